>>> rtl/core/plo_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// positional ordered list. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plo_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LIST   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOPOS = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} plo_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;   // input transfer this cycle
		logic step;   // emit the next listed element
	} plo_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;    // output register can load this cycle
		logic list_start;  // input item is a list of a non-empty list
		logic list_end;    // list index points at the last element
	} plo_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/plo_ctrl.sv
// Controller for the positional ordered list: accepts items and sequences
// the list stream. Depends on plo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plo_ctrl
	import plo_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire plo_stat_t stat,
	output plo_cmd_t       cmd
);

	plo_state_t state_q;
	plo_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && stat.out_free && stat.list_start) begin
					state_d = S_LIST;
				end
			end
			S_LIST: begin
				if (stat.out_free && stat.list_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				cmd.take = in_valid && stat.out_free;
			end
			S_LIST: begin
				cmd.step = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
				cmd      = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/plo_dp.sv
// Datapath for the positional ordered list: element cells with parallel
// shift, element count, list index and output register. Depends on plo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plo_dp
	import plo_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire plo_cmd_t                 cmd,
	output plo_stat_t                     stat,
	input  wire logic [1:0]               operation,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      value_res,
	output logic [CNT_W-1:0]              count,
	output logic                          last
);

	logic [DATA_W-1:0] elem_q [DEPTH];
	logic [DATA_W-1:0] elem_d [DEPTH];
	logic [CNT_W-1:0]  elem_cnt_q;
	logic [IDX_W-1:0]  list_idx_q;

	logic                     out_vld_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] value_res_q;
	logic [CNT_W-1:0]         count_q;
	logic                     last_q;

	logic [1:0]               status_d;
	logic signed [DATA_W-1:0] value_res_d;
	logic [CNT_W-1:0]         count_d;
	logic                     last_d;

	logic [CMP_W-1:0] n_ext;
	logic [CMP_W-1:0] pos_ext;
	logic             full;
	logic             empty;
	logic             nopos;
	logic [CMP_W-1:0] ins_idx;
	logic [CMP_W-1:0] del_idx;
	logic             ins_ok;
	logic             del_ok;
	logic [IDX_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [CNT_W-1:0] n_m1;
	logic             load;
	logic             out_free;

	assign n_ext   = CMP_W'(elem_cnt_q);
	assign pos_ext = CMP_W'(position);
	assign full    = (elem_cnt_q == CNT_W'(DEPTH));
	assign empty   = (elem_cnt_q == '0);
	assign nopos   = (pos_ext > n_ext);
	assign n_m1    = elem_cnt_q - CNT_W'(1);

	// position zero or past the end appends
	assign ins_idx = ((pos_ext == '0) || nopos) ? n_ext : (pos_ext - CMP_W'(1));
	assign del_idx = (pos_ext == '0) ? (n_ext - CMP_W'(1)) : (pos_ext - CMP_W'(1));

	assign ins_ok = cmd.take && (operation == OP_INSERT) && !full;
	assign del_ok = cmd.take && (operation == OP_DELETE) && !empty && !nopos;

	assign rd_addr = cmd.step ? list_idx_q : del_idx[IDX_W-1:0];
	assign rd_data = elem_q[rd_addr];

	// each cell takes its own value, the inserted value, its left neighbor or its right neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = elem_q[g];
		end else begin : g_mid
			assign left_w = elem_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_final
			assign right_w = elem_q[g];
		end else begin : g_inner
			assign right_w = elem_q[g+1];
		end
		always_comb begin
			elem_d[g] = elem_q[g];
			if (ins_ok) begin
				if (CMP_W'(g) == ins_idx) begin
					elem_d[g] = value;
				end else if ((CMP_W'(g) > ins_idx) && (CMP_W'(g) <= n_ext)) begin
					elem_d[g] = left_w;
				end
			end else if (del_ok && (CMP_W'(g) >= del_idx)) begin
				elem_d[g] = right_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			elem_q[i] <= elem_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			list_idx_q <= '0;
		end else begin
			if (ins_ok) begin
				elem_cnt_q <= elem_cnt_q + CNT_W'(1);
			end else if (del_ok) begin
				elem_cnt_q <= n_m1;
			end
			if (cmd.take) begin
				list_idx_q <= '0;
			end else if (cmd.step) begin
				list_idx_q <= list_idx_q + IDX_W'(1);
			end
		end
	end

	// a non-empty list emits through step; unused code emits nothing
	assign load = cmd.step || (cmd.take && (operation != OP_LIST || empty)
		&& (operation == OP_INSERT || operation == OP_DELETE || operation == OP_LIST));

	always_comb begin
		status_d    = ST_OK;
		value_res_d = '0;
		count_d     = elem_cnt_q;
		last_d      = 1'b1;
		if (cmd.step) begin
			value_res_d = rd_data;
			last_d      = (CNT_W'(list_idx_q) == n_m1);
		end else if (operation == OP_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = elem_cnt_q + CNT_W'(1);
			end
		end else if (operation == OP_DELETE) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else if (nopos) begin
				status_d = ST_NOPOS;
			end else begin
				value_res_d = rd_data;
				count_d     = n_m1;
			end
		end else begin
			status_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= status_d;
			value_res_q <= value_res_d;
			count_q     <= count_d;
			last_q      <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_free = !out_vld_q || out_ready;

	assign stat.out_free   = out_free;
	assign stat.list_start = (operation == OP_LIST) && !empty;
	assign stat.list_end   = (CNT_W'(list_idx_q) == n_m1);

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign value_res = value_res_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

`default_nettype wire

>>> rtl/core/positional_ordered_list_top.sv
// Top level of the positional ordered list: controller plus datapath.
// Depends on plo_pkg, plo_ctrl and plo_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, position, value.
//   Output channel (out_valid/out_ready) carries status, value_res, count,
//   last. Every item transfer gives one result, except a list of a
//   non-empty list (one result per element, last set on the final one) and
//   the unused operation code (no result).
//   Insert and delete shift all cells in parallel in the transfer cycle;
//   their result is in the output register the next cycle, so one such
//   item per cycle while the receiver keeps out_ready high.
//   A list of N elements holds in_ready low after the transfer until the
//   last element loads, streaming one element per cycle while out_ready
//   stays high; the list state is entered before the first element loads.
//   The single output register sets the pace: in_ready drops while it holds
//   a result that the receiver stalls, and the stream pauses with it.
//   Reset empties the list and the output register; element cells keep
//   their contents but are never read beyond the element count.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_top
	import plo_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               operation,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      value_res,
	output logic [CNT_W-1:0]              count,
	output logic                          last
);

	plo_cmd_t  cmd;
	plo_stat_t stat;

	plo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value_res (value_res),
		.count     (count),
		.last      (last)
	);

	// hold input while a stalled result occupies the output register
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while output stalled");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == OP_INSERT) |=> (out_valid && last))
		else $error("insert gave no final result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CNT_W'(DEPTH)))
		else $error("count beyond depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
		else $error("full status with room left");

endmodule

`default_nettype wire

>>> tb/tb_positional_ordered_list_top.sv
// Self-checking testbench for positional_ordered_list_top: a directed table, then
// random insert/delete/list and unused-code traffic with random stalls on both channels.
// Depends on plo_pkg and the positional_ordered_list_top RTL.
`timescale 1ns / 1ps

module tb_positional_ordered_list_top
	import plo_pkg::*;
();

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 280;
	localparam int IDLE_PCT = 34;
	localparam int DRAIN_CYCLES = 4 * DEPTH;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] value_res;
		logic [CNT_W-1:0]  count;
		logic              last;
	} list_result_t;

	// fixed rows carry the expected status and count; their value_res is 0, last is 1
	typedef struct packed {
		logic [1:0]        op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic              fixed;
		logic [1:0]        fix_status;
		logic [CNT_W-1:0]  fix_count;
	} stim_row_t;

	localparam stim_row_t DIRECTED [27] = '{
		'{OP_DELETE, 5'd0,  32'h00000000, 1'b1, ST_EMPTY, 5'd0},
		'{OP_LIST,   5'd0,  32'h00000000, 1'b1, ST_EMPTY, 5'd0},
		'{OP_INSERT, 5'd0,  32'h7FFFFFFF, 1'b1, ST_OK,    5'd1},
		'{OP_INSERT, 5'd1,  32'h80000000, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd31, 32'hFFFFFFFF, 1'b0, ST_OK,    5'd0},
		'{OP_LIST,   5'd0,  32'h00000000, 1'b0, ST_OK,    5'd0},
		'{OP_DELETE, 5'd4,  32'h00000000, 1'b1, ST_NOPOS, 5'd3},
		'{OP_DELETE, 5'd0,  32'h00000000, 1'b0, ST_OK,    5'd0},
		'{OP_UNUSED, 5'd16, 32'h5555AAAA, 1'b0, ST_OK,    5'd0},
		'{OP_DELETE, 5'd31, 32'h00000000, 1'b1, ST_NOPOS, 5'd2},
		'{OP_INSERT, 5'd1,  32'h00000001, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd16, 32'hAAAAAAAA, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd0,  32'h55555555, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd2,  32'hDEADBEEF, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd17, 32'h12345678, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd8,  32'hFFFF0000, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd3,  32'h0000FFFF, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd0,  32'h80000001, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd5,  32'h7FFFFFFE, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd12, 32'h00000000, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd1,  32'hC0000000, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd9,  32'h3FFFFFFF, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd14, 32'h0F0F0F0F, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd2,  32'hF0F0F0F0, 1'b0, ST_OK,    5'd0},
		'{OP_INSERT, 5'd0,  32'h13579BDF, 1'b1, ST_FULL,  5'd16},
		'{OP_LIST,   5'd0,  32'h00000000, 1'b0, ST_OK,    5'd0},
		'{OP_DELETE, 5'd16, 32'h00000000, 1'b0, ST_OK,    5'd0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               operation;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] value_res;
	logic [CNT_W-1:0]         count;
	logic                     last;

	// shadow copy of the list, front at index 0
	logic [DATA_W-1:0] shadow_list [DEPTH];
	int                shadow_len;
	list_result_t      expected_results [$];
	bit                failed;
	bit                steady;
	int                cycles;

	positional_ordered_list_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value_res (value_res),
		.count     (count),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void note_result(input logic [1:0] st, input logic [DATA_W-1:0] v,
			input int cnt, input bit lst, input bit record);
		list_result_t r;
		r.status    = st;
		r.value_res = v;
		r.count     = CNT_W'(cnt);
		r.last      = lst;
		if (record)
			expected_results.push_back(r);
	endfunction

	// apply one accepted item to the shadow list; queue its results if record is set
	function automatic void advance_list(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input bit record);
		int at;
		int i;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= DEPTH) begin
					note_result(ST_FULL, '0, shadow_len, 1'b1, record);
				end else begin
					at = (pos == 0 || pos > shadow_len) ? shadow_len : int'(pos) - 1;
					for (i = shadow_len; i > at; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[at] = val;
					shadow_len++;
					note_result(ST_OK, '0, shadow_len, 1'b1, record);
				end
			end
			OP_DELETE: begin
				if (shadow_len == 0) begin
					note_result(ST_EMPTY, '0, 0, 1'b1, record);
				end else if (pos > shadow_len) begin
					note_result(ST_NOPOS, '0, shadow_len, 1'b1, record);
				end else begin
					at = (pos == 0) ? shadow_len - 1 : int'(pos) - 1;
					val = shadow_list[at];
					for (i = at; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
					note_result(ST_OK, val, shadow_len, 1'b1, record);
				end
			end
			OP_LIST: begin
				if (shadow_len == 0)
					note_result(ST_EMPTY, '0, 0, 1'b1, record);
				for (i = 0; i < shadow_len; i++)
					note_result(ST_OK, shadow_list[i], shadow_len,
						i + 1 == shadow_len, record);
			end
			default: ;
		endcase
	endfunction

	// present one item and hold it until the transfer
	task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		value     <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic void check_field(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, %s %0d value %h count %0d last %b",
					$time, "actual status", status, value_res, count, last);
				failed = 1'b1;
			end else begin
				list_result_t want;
				want = expected_results.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(status));
				check_field("value_res", want.value_res, value_res);
				check_field("count", DATA_W'(want.count), DATA_W'(count));
				check_field("last", DATA_W'(want.last), DATA_W'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_positional_ordered_list_top NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t         row;
		int                r;
		int                taken;
		int                pick;
		bit                filling;
		logic [1:0]        op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = OP_INSERT;
		position   = '0;
		value      = '0;
		out_ready  = 1'b0;
		shadow_len = 0;
		failed     = 1'b0;
		steady     = 1'b0;
		cycles     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(DIRECTED); r++) begin
			row = DIRECTED[r];
			send_item(row.op, row.pos, row.val);
			if (row.fixed) begin
				note_result(row.fix_status, '0, int'(row.fix_count), 1'b1, 1'b1);
				advance_list(row.op, row.pos, row.val, 1'b0);
			end else begin
				advance_list(row.op, row.pos, row.val, 1'b1);
			end
		end

		// alternate fill and drain sweeps so full and empty are hit again and again
		filling = 1'b1;
		taken = 0;
		while (taken < RANDOM_ITEMS) begin
			steady = (taken >= 120 && taken < 200);
			if (shadow_len == DEPTH)
				filling = 1'b0;
			else if (shadow_len == 0)
				filling = 1'b1;
			pick = $urandom_range(99);
			if (pick < 4)
				op = OP_UNUSED;
			else if (pick < 16)
				op = OP_LIST;
			else if (pick < (filling ? 72 : 34))
				op = OP_INSERT;
			else
				op = OP_DELETE;
			pick = $urandom_range(9);
			if (pick < 2)
				pos = '0;
			else if (pick < 8)
				pos = POS_W'($urandom_range(1, shadow_len + 1));
			else
				pos = POS_W'($urandom_range(0, 31));
			pick = $urandom_range(7);
			case (pick)
				0: val = 32'h80000000;
				1: val = 32'h7FFFFFFF;
				2: val = 32'hFFFFFFFF;
				default: val = $urandom;
			endcase
			send_item(op, pos, val);
			advance_list(op, pos, val, 1'b1);
			if (op != OP_UNUSED)
				taken++;
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("tb_positional_ordered_list_top OK");
		else
			$display("tb_positional_ordered_list_top NOT OK");
		$finish;
	end

endmodule
